/* src/psv_pkg.sv */
`default_nettype none

package psv_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CMD_W      = 2;
    localparam int DRAW_W     = 16;
    localparam int COEF_W     = 16;
    localparam int INSTR_W    = 3;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int SUM_W      = SAMPLE_W + 1;
    localparam int MAG_W      = 36;
    localparam int ACC_W      = MAG_W + 1;
    localparam int PROD_W     = MAG_W + COEF_W;

    localparam logic [CFG_DATA_W-1:0] CAP_RESET = CFG_DATA_W'(201);

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_INSTRUMENT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_CAPACITY = 1'b1;

    localparam logic [INSTR_W-1:0] INSTR_GUITAR  = 3'd0;
    localparam logic [INSTR_W-1:0] INSTR_PIANO   = 3'd1;
    localparam logic [INSTR_W-1:0] INSTR_DRUM    = 3'd2;
    localparam logic [INSTR_W-1:0] INSTR_BELL    = 3'd3;
    localparam logic [INSTR_W-1:0] INSTR_SITAR   = 3'd4;
    localparam logic [INSTR_W-1:0] INSTR_KALIMBA = 3'd5;

    localparam logic [COEF_W-1:0] G_GUITAR  = 16'd65274;
    localparam logic [COEF_W-1:0] G_PIANO   = 16'd65339;
    localparam logic [COEF_W-1:0] G_DRUM    = 16'd64881;
    localparam logic [COEF_W-1:0] G_BELL    = 16'd65143;
    localparam logic [COEF_W-1:0] G_SITAR   = 16'd65208;
    localparam logic [COEF_W-1:0] G_KALIMBA = 16'd65405;
    localparam logic [COEF_W-1:0] AP_COEF   = 16'd52429;

    localparam logic [DRAW_W-1:0] TH_DRUM    = 16'd32768;
    localparam logic [DRAW_W-1:0] TH_SITAR   = 16'd328;
    localparam logic [DRAW_W-1:0] TH_KALIMBA = 16'd656;

    localparam int SHIFT_HALF = 16;
    localparam int SHIFT_FLIP = 17;
    localparam int SHIFT_BELL = 33;

    localparam int SAT_MAG_POS = 2 ** (SAMPLE_W - 1) - 1;
    localparam int SAT_MAG_NEG = 2 ** (SAMPLE_W - 1);

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  mag;
        logic [COEF_W-1:0] coef;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_rsp;

endpackage

`default_nettype wire

/* src/plucked_string_voice_unit.sv */
`default_nettype none

// Karplus-Strong plucked-string voice. Commands arrive on the slave stream:
// load pushes one noise sample into the delay-line queue (dropped when the
// queue is full), clear empties it, and tick pops the oldest sample, reads
// the new front, pushes a damped value and returns one result on the master
// stream. A tick waits on the damping product, which runs through a
// bit-serial multiplier (twice for the bell all-pass), and the two reads
// share the single read port of the delay memory. The delay memory needs
// no clearing pass; writing the loop capacity empties the queue.
module plucked_string_voice_unit
    import psv_pkg::*;
#(
    parameter int LOOP_DEPTH = 2048
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [31:0]           i_s_axis_tdata,  // load_sample [15:0], random_draw [31:16]
    input  wire logic [CMD_W-1:0]      i_s_axis_tuser,  // command [1:0]

    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [SAMPLE_W-1:0]   o_m_axis_tdata,  // sample [15:0]
    output logic      [0:0]            o_m_axis_tuser   // was_empty [0]
);

    localparam int AW = $clog2(LOOP_DEPTH);
    localparam int CW = $clog2(LOOP_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_CALC,
        S_MUL1,
        S_ACC,
        S_MUL2,
        S_PUSH,
        S_OUT
    } t_state;

    function automatic logic [CW-1:0] clamp_cap(input logic [CFG_DATA_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w == 32'd0) begin
            w = 32'd1;
        end
        if (w > 32'(LOOP_DEPTH)) begin
            w = 32'(LOOP_DEPTH);
        end
        return CW'(w);
    endfunction

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i,
                                               input logic [CW-1:0] cap);
        logic [CW-1:0] n;
        n = CW'(i) + 1'b1;
        return (n >= cap) ? '0 : AW'(n);
    endfunction

    t_state                   r_state, n_state;
    logic [INSTR_W-1:0]       r_instr, n_instr;
    logic [CW-1:0]            r_cap, n_cap;
    logic [AW-1:0]            r_head, n_head;
    logic [AW-1:0]            r_tail, n_tail;
    logic [CW-1:0]            r_count, n_count;
    logic [SUM_W-1:0]         r_ap1, n_ap1;
    logic [SUM_W-1:0]         r_ap2, n_ap2;
    logic [SAMPLE_W-1:0]      r_a, n_a;
    logic [SAMPLE_W-1:0]      r_b, n_b;
    logic [DRAW_W-1:0]        r_draw, n_draw;
    logic                     r_was_empty, n_was_empty;
    logic                     r_neg, n_neg;
    logic [SAMPLE_W-1:0]      r_res, n_res;
    logic                     r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0]      r_out_data, n_out_data;
    logic                     r_out_empty, n_out_empty;

    logic                     s_accept;
    logic [CW-1:0]            cfg_cap;
    logic [CW-1:0]            reset_cap;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [SAMPLE_W-1:0]      wr_data;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [SAMPLE_W-1:0]      rd_data;

    t_mul_req                 mul_req;
    t_mul_rsp                 mul_rsp;

    logic [COEF_W-1:0]        gain;
    logic [DRAW_W-1:0]        thresh;
    logic                     m_flip;
    logic                     m_bell;

    logic [SUM_W-1:0]         sum;
    logic [SUM_W:0]           sum_x;
    logic [SUM_W:0]           sum_mag;
    logic [SUM_W:0]           diff;
    logic [SUM_W:0]           diff_mag;
    logic [ACC_W-1:0]         p_signed;
    logic [ACC_W-1:0]         ap1_term;
    logic [ACC_W-1:0]         acc;
    logic [ACC_W-1:0]         acc_mag;
    logic [PROD_W-1:0]        shifted;
    logic [PROD_W-1:0]        limit;
    logic [SAMPLE_W-1:0]      damped;
    logic [AW-1:0]            head_next;
    logic [AW-1:0]            tail_next;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_cap         = clamp_cap(i_cfg_data);
    assign reset_cap       = clamp_cap(CAP_RESET);

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_empty;

    always_comb begin
        gain   = G_GUITAR;
        thresh = '0;
        m_flip = 1'b0;
        m_bell = 1'b0;
        case (r_instr)
            INSTR_PIANO: begin
                gain = G_PIANO;
            end
            INSTR_DRUM: begin
                gain   = G_DRUM;
                thresh = TH_DRUM;
                m_flip = 1'b1;
            end
            INSTR_BELL: begin
                gain   = G_BELL;
                m_bell = 1'b1;
            end
            INSTR_SITAR: begin
                gain   = G_SITAR;
                thresh = TH_SITAR;
                m_flip = 1'b1;
            end
            INSTR_KALIMBA: begin
                gain   = G_KALIMBA;
                thresh = TH_KALIMBA;
                m_flip = 1'b1;
            end
            default: begin
                gain = G_GUITAR;
            end
        endcase
    end

    // The datapath works in sign and magnitude, so truncation toward zero is
    // a plain right shift of the magnitude.
    always_comb begin
        sum      = {r_a[SAMPLE_W-1], r_a} + {r_b[SAMPLE_W-1], r_b};
        sum_x    = {sum[SUM_W-1], sum};
        sum_mag  = sum_x[SUM_W] ? -sum_x : sum_x;
        diff     = {r_ap2[SUM_W-1], r_ap2} - sum_x;
        diff_mag = diff[SUM_W] ? -diff : diff;

        p_signed = r_neg ? -mul_rsp.prod[ACC_W-1:0] : mul_rsp.prod[ACC_W-1:0];
        ap1_term = {{(ACC_W - SUM_W - 16){r_ap1[SUM_W-1]}}, r_ap1, 16'b0};
        acc      = p_signed + ap1_term;
        acc_mag  = acc[ACC_W-1] ? -acc : acc;

        if (m_bell) begin
            shifted = mul_rsp.prod >> SHIFT_BELL;
        end else if (m_flip) begin
            shifted = mul_rsp.prod >> SHIFT_FLIP;
        end else begin
            shifted = mul_rsp.prod >> SHIFT_HALF;
        end
        limit = r_neg ? PROD_W'(SAT_MAG_NEG) : PROD_W'(SAT_MAG_POS);
        if (shifted > limit) begin
            damped = r_neg ? {1'b1, {(SAMPLE_W - 1){1'b0}}}
                           : {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end else begin
            damped = r_neg ? -shifted[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
        end

        head_next = next_idx(r_head, r_cap);
        tail_next = next_idx(r_tail, r_cap);
    end

    always_comb begin
        n_state     = r_state;
        n_instr     = r_instr;
        n_cap       = r_cap;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_ap1       = r_ap1;
        n_ap2       = r_ap2;
        n_a         = r_a;
        n_b         = r_b;
        n_draw      = r_draw;
        n_was_empty = r_was_empty;
        n_neg       = r_neg;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_empty = r_out_empty;

        wr_en   = 1'b0;
        wr_addr = tail_next;
        wr_data = i_s_axis_tdata[SAMPLE_W-1:0];
        rd_en   = 1'b0;
        rd_addr = r_head;
        mul_req = '{start: 1'b0, mag: '0, coef: gain};

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INSTRUMENT: begin
                    n_instr = i_cfg_data[INSTR_W-1:0];
                end
                REG_LOOP_CAPACITY: begin
                    n_cap   = cfg_cap;
                    n_head  = '0;
                    n_tail  = AW'(cfg_cap - 1'b1);
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    case (i_s_axis_tuser)
                        CMD_LOAD: begin
                            if (r_count < r_cap) begin
                                wr_en   = 1'b1;
                                n_tail  = tail_next;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_head  = '0;
                            n_tail  = AW'(r_cap - 1'b1);
                            n_count = '0;
                        end
                        CMD_TICK: begin
                            n_draw      = i_s_axis_tdata[31:16];
                            n_was_empty = (r_count == '0);
                            if (r_count == '0) begin
                                n_a     = '0;
                                n_b     = '0;
                                n_state = S_CALC;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_RD_A;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD_A: begin
                n_a     = rd_data;
                n_head  = head_next;
                n_count = r_count - 1'b1;
                if (r_count != CW'(1)) begin
                    rd_en   = 1'b1;
                    rd_addr = head_next;
                    n_state = S_RD_B;
                end else begin
                    n_b     = '0;
                    n_state = S_CALC;
                end
            end
            S_RD_B: begin
                n_b     = rd_data;
                n_state = S_CALC;
            end
            S_CALC: begin
                mul_req.start = 1'b1;
                if (m_bell) begin
                    mul_req.mag  = MAG_W'(diff_mag);
                    mul_req.coef = AP_COEF;
                    n_neg        = diff[SUM_W];
                end else if (m_flip) begin
                    mul_req.mag = MAG_W'(sum_mag);
                    n_neg       = sum[SUM_W-1] ^ (r_draw < thresh);
                end else begin
                    mul_req.mag = MAG_W'(sum_mag >> 1);
                    n_neg       = sum[SUM_W-1];
                end
                n_state = S_MUL1;
            end
            S_MUL1: begin
                if (mul_rsp.done) begin
                    n_state = m_bell ? S_ACC : S_PUSH;
                end
            end
            S_ACC: begin
                mul_req.start = 1'b1;
                mul_req.mag   = acc_mag[MAG_W-1:0];
                mul_req.coef  = G_BELL;
                n_neg         = acc[ACC_W-1];
                n_ap2         = r_ap1;
                n_ap1         = sum;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                if (mul_rsp.done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                wr_en   = 1'b1;
                wr_data = damped;
                n_tail  = tail_next;
                n_count = r_count + 1'b1;
                n_res   = (r_count != '0) ? r_b : damped;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_out_empty = r_was_empty;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_instr     <= INSTR_GUITAR;
            r_cap       <= reset_cap;
            r_head      <= '0;
            r_tail      <= AW'(reset_cap - 1'b1);
            r_count     <= '0;
            r_ap1       <= '0;
            r_ap2       <= '0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
            r_out_empty <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_instr     <= n_instr;
            r_cap       <= n_cap;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_ap1       <= n_ap1;
            r_ap2       <= n_ap2;
            r_out_valid <= n_out_valid;
            r_out_data  <= n_out_data;
            r_out_empty <= n_out_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_draw      <= n_draw;
        r_was_empty <= n_was_empty;
        r_neg       <= n_neg;
        r_res       <= n_res;
    end

    psv_delay_ram #(
        .DEPTH (LOOP_DEPTH),
        .ADDR_W(AW)
    ) u_delay_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    psv_serial_mul u_serial_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_rsp  (mul_rsp)
    );

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("fill count exceeds loop capacity");

    a_index_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_head) < r_cap) && (CW'(r_tail) < r_cap))
        else $error("queue index outside loop capacity");

    a_tick_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (i_s_axis_tuser == CMD_TICK)) |=> !o_s_axis_tready)
        else $error("new transaction taken while a tick is in progress");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_OUT))
        else $error("result presented outside the output step");

endmodule

`default_nettype wire

/* src/psv_delay_ram.sv */
`default_nettype none

module psv_delay_ram
    import psv_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_wr_en,
    input  wire logic [ADDR_W-1:0]   i_wr_addr,
    input  wire logic [SAMPLE_W-1:0] i_wr_data,
    input  wire logic                i_rd_en,
    input  wire logic [ADDR_W-1:0]   i_rd_addr,
    output logic      [SAMPLE_W-1:0] o_rd_data
);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

`default_nettype wire

/* src/psv_serial_mul.sv */
`default_nettype none

module psv_serial_mul
    import psv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    localparam int CNT_W = $clog2(COEF_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MAG_W-1:0]   r_hi;
    logic [COEF_W-1:0]  r_lo;
    logic [MAG_W-1:0]   r_mag;

    logic [MAG_W:0]     sum;
    logic [MAG_W-1:0]   n_hi;
    logic [COEF_W-1:0]  n_lo;

    // One multiplier bit per cycle: add the multiplicand, then shift the
    // partial product right into the low word.
    always_comb begin
        sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mag} : '0);
        n_hi = sum[MAG_W:1];
        n_lo = {sum[0], r_lo[COEF_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(COEF_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_hi  <= '0;
            r_lo  <= i_req.coef;
            r_mag <= i_req.mag;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_hi, r_lo};

endmodule

`default_nettype wire
